// ===== sv/bflm_pkg.sv =====
// Shared types and constants for the buffer free-list manager.
package bflm_pkg;

   localparam int NUM_ITEMS      = 64;
   localparam int RESERVED_ITEMS = 2;
   localparam int PCT_SCALE      = 100;

   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;
   localparam int PCT_W   = 7;
   localparam int PROD_W  = 14;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_THRESHOLD_PERCENT = 1'b0,
      CSR_NOTIFY_ENABLE     = 1'b1
   } csr_index_type;

   localparam int CSR_INDEX_W = 1;

   typedef struct packed {
      logic               func;
      logic               item_type;
      logic [INDEX_W-1:0] item_index;
   } req_type;

   typedef struct packed {
      logic               granted;
      logic [INDEX_W-1:0] granted_index;
      logic [COUNT_W-1:0] free_count;
      logic               notify;
      logic               overflow_error;
   } rsp_type;

   // Shift command broadcast to every stack cell
   typedef struct packed {
      logic               push;
      logic               pop;
      logic [INDEX_W-1:0] push_index;
   } stack_cmd_type;

endpackage

// ===== sv/bflm_cell.sv =====
// One entry of the shifting free stack.
module bflm_cell #(
   parameter int INIT_INDEX = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bflm_pkg::stack_cmd_type        cmd,
   input  logic [bflm_pkg::INDEX_W-1:0]   above_index,
   input  logic [bflm_pkg::INDEX_W-1:0]   below_index,
   output logic [bflm_pkg::INDEX_W-1:0]   entry_index
);
   import bflm_pkg::*;

   logic [INDEX_W-1:0] entry_ff;
   logic [INDEX_W-1:0] entry_in;

   // Take from the neighbor toward the top on push, from below on pop
   always_comb begin
      entry_in = entry_ff;
      if (cmd.push) begin
         entry_in = above_index;
      end else if (cmd.pop) begin
         entry_in = below_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= INDEX_W'(INIT_INDEX);
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry_index = entry_ff;

endmodule

// ===== sv/bflm_stack.sv =====
// Row of stack cells; cell 0 is the top of the free stack.
module bflm_stack (
   input  logic                           clock,
   input  logic                           reset,
   input  bflm_pkg::stack_cmd_type        cmd,
   output logic [bflm_pkg::INDEX_W-1:0]   top_index
);
   import bflm_pkg::*;

   logic [INDEX_W-1:0] entry [NUM_ITEMS];

   // Chain the cells: each sees its upper and lower neighbor
   for (genvar j = 0; j < NUM_ITEMS; j++) begin : g_cell
      logic [INDEX_W-1:0] above;
      logic [INDEX_W-1:0] below;

      if (j == 0) begin : g_top
         assign above = cmd.push_index;
      end else begin : g_mid_up
         assign above = entry[j-1];
      end

      if (j == NUM_ITEMS-1) begin : g_bottom
         assign below = entry[j];
      end else begin : g_mid_dn
         assign below = entry[j+1];
      end

      bflm_cell #(
         .INIT_INDEX(NUM_ITEMS-1-j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .above_index(above),
         .below_index(below),
         .entry_index(entry[j])
      );
   end

   assign top_index = entry[0];

endmodule

// ===== sv/buffer_free_list_manager_unit.sv =====
// Buffer free-list manager: LIFO of free slot indices with reserve, free and notify.
//
// One access per clock: start is taken whenever it is high (busy stays low) and its
// result appears on rsp_data, marked by rsp_strobe, for exactly one cycle on the
// following cycle. The free stack is a row of 64 shifting cells with the top in
// cell 0, so a push or pop shifts every cell at once, regardless of fill level. After
// reset the stack holds every slot, highest index on top. The notify threshold
// NUM_ITEMS*threshold_percent/100 is compared without a divider, as
// NUM_ITEMS*percent <= 100*free_count + 99.
module buffer_free_list_manager_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bflm_pkg::req_type                 req_data,
   output logic                              rsp_strobe,
   output bflm_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [bflm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bflm_pkg::PCT_W-1:0]        csr_wdata
);
   import bflm_pkg::*;

   logic [PCT_W-1:0]   threshold_ff;
   logic               notify_en_ff;
   logic [COUNT_W-1:0] free_total_ff;
   logic [COUNT_W-1:0] free_total_in;
   logic               rsp_strobe_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;
   stack_cmd_type      cmd;
   logic [INDEX_W-1:0] top_index;
   logic               transfer;
   logic               pop_ok;
   logic               push_ok;
   logic [PROD_W-1:0]  thr_scaled;
   logic [PROD_W-1:0]  count_limit;

   assign busy     = 1'b0;
   assign transfer = start && !busy;

   // Decide pop or push against the current fill level
   always_comb begin
      if (req_data.item_type) begin
         pop_ok = free_total_ff > COUNT_W'(RESERVED_ITEMS);
      end else begin
         pop_ok = free_total_ff != '0;
      end
      push_ok = free_total_ff < COUNT_W'(NUM_ITEMS);

      cmd.pop        = transfer && !req_data.func && pop_ok;
      cmd.push       = transfer && req_data.func && push_ok;
      cmd.push_index = req_data.item_index;

      free_total_in = free_total_ff;
      if (cmd.pop) begin
         free_total_in = free_total_ff - COUNT_W'(1);
      end else if (cmd.push) begin
         free_total_in = free_total_ff + COUNT_W'(1);
      end
   end

   // Compare threshold by cross-multiplying with the percent scale
   assign thr_scaled  = PROD_W'(NUM_ITEMS) * PROD_W'(threshold_ff);
   assign count_limit = PROD_W'(PCT_SCALE) * PROD_W'(free_total_in) + PROD_W'(PCT_SCALE - 1);

   // Build the result for this access
   always_comb begin
      rsp_data_in.granted        = cmd.pop;
      rsp_data_in.granted_index  = cmd.pop ? top_index : '0;
      rsp_data_in.free_count     = free_total_in;
      rsp_data_in.notify         = req_data.func && notify_en_ff && (thr_scaled <= count_limit);
      rsp_data_in.overflow_error = req_data.func && !push_ok;
   end

   bflm_stack u_stack (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .top_index(top_index)
   );

   // Hold configuration, fill count and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= PCT_W'(50);
         notify_en_ff  <= 1'b0;
         free_total_ff <= COUNT_W'(NUM_ITEMS);
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD_PERCENT: threshold_ff <= csr_wdata;
               CSR_NOTIFY_ENABLE:     notify_en_ff <= csr_wdata[0];
               default:               ;
            endcase
         end
         free_total_ff <= free_total_in;
         rsp_strobe_ff <= transfer;
      end
   end

   // Capture result payload on each transfer
   always_ff @(posedge clock) begin
      if (transfer) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the buffer free-list manager: directed table, then random sweeps.
module testbench;
   import bflm_pkg::*;

   localparam logic FUNC_RESERVE    = 1'b0;
   localparam logic FUNC_FREE       = 1'b1;
   localparam logic TYPE_REQUEST    = 1'b0;
   localparam logic TYPE_INDICATION = 1'b1;
   localparam int   RANDOM_ITEMS    = 500;
   localparam int   MAX_GAP         = 14;

   typedef enum logic [0:0] {
      ROW_ACCESS,
      ROW_REG
   } row_kind_type;

   // One row of the directed table: an access or a register write
   typedef struct packed {
      row_kind_type       kind;
      req_type            req;
      csr_index_type      reg_index;
      logic [PCT_W-1:0]   reg_value;
      logic               typed;
      rsp_type            want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [PCT_W-1:0]  csr_wdata = '0;

   // Shadow copy of the free stack and the registers
   logic [INDEX_W-1:0] slot_stack [NUM_ITEMS];
   logic [COUNT_W-1:0] slots_free;
   logic [PCT_W-1:0]   pct_reg;
   logic               notify_on;

   rsp_type      pending_rsp [$];
   stim_row_type directed_rows [$];
   bit        burst_mode = 1'b0;
   int        errors = 0;
   int        accesses = 0;
   int        grants = 0;
   int        refusals = 0;
   int        overflows = 0;
   int        notifies = 0;
   int        reg_writes = 0;

   buffer_free_list_manager_unit uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // Hold reset from time zero, then release
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the handshake or a result never comes
   initial begin
      #400000;
      $display("FAIL buffer_free_list_manager_unit");
      $finish;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
   endtask

   function automatic void reset_tracker();
      for (int k = 0; k < NUM_ITEMS; k++)
         slot_stack[k] = INDEX_W'(k);
      slots_free = COUNT_W'(NUM_ITEMS);
      pct_reg    = PCT_W'(50);
      notify_on  = 1'b0;
   endfunction

   // Apply one accepted access to the shadow state and return its result
   function automatic rsp_type track_access(input req_type r);
      rsp_type res;
      bit      ok;
      int      thr;
      res = '0;
      if (r.func == FUNC_RESERVE) begin
         if (r.item_type == TYPE_REQUEST)
            ok = slots_free > 0;
         else
            ok = slots_free > RESERVED_ITEMS;
         if (ok) begin
            slots_free--;
            res.granted       = 1'b1;
            res.granted_index = slot_stack[slots_free];
            grants++;
         end else begin
            refusals++;
         end
      end else begin
         if (slots_free < NUM_ITEMS) begin
            slot_stack[slots_free] = r.item_index;
            slots_free++;
         end else begin
            res.overflow_error = 1'b1;
            overflows++;
         end
         thr = (NUM_ITEMS * int'(pct_reg)) / PCT_SCALE;
         if (notify_on && int'(slots_free) >= thr) begin
            res.notify = 1'b1;
            notifies++;
         end
      end
      res.free_count = slots_free;
      return res;
   endfunction

   task automatic wait_drained();
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Present one access after a random gap (none in burst mode) and hold it until the transfer
   task automatic send_access(input req_type r, input bit typed, input rsp_type want);
      int      gap;
      bit      taken;
      rsp_type pred;
      gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         taken = (busy === 1'b0);
         @(posedge clock);
      end while (!taken);
      pred = track_access(r);
      accesses++;
      pending_rsp.push_back(typed ? want : pred);
   endtask

   // Write a register once the block has gone idle
   task automatic write_reg(input csr_index_type idx, input logic [PCT_W-1:0] value);
      start <= 1'b0;
      wait_drained();
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_THRESHOLD_PERCENT)
         pct_reg = value;
      else
         notify_on = value[0];
      reg_writes++;
   endtask

   function automatic rsp_type mk_rsp(input logic g, input int gi, input int cnt,
                                      input logic n, input logic o);
      rsp_type res;
      res.granted        = g;
      res.granted_index  = INDEX_W'(gi);
      res.free_count     = COUNT_W'(cnt);
      res.notify         = n;
      res.overflow_error = o;
      return res;
   endfunction

   task automatic add_access(input logic f, input logic t, input int idx);
      stim_row_type row;
      row                = '0;
      row.kind           = ROW_ACCESS;
      row.req.func       = f;
      row.req.item_type  = t;
      row.req.item_index = INDEX_W'(idx);
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic f, input logic t, input int idx, input rsp_type want);
      stim_row_type row;
      row                = '0;
      row.kind           = ROW_ACCESS;
      row.req.func       = f;
      row.req.item_type  = t;
      row.req.item_index = INDEX_W'(idx);
      row.typed          = 1'b1;
      row.want           = want;
      directed_rows.push_back(row);
   endtask

   task automatic add_reg(input csr_index_type idx, input int value);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_REG;
      row.reg_index = idx;
      row.reg_value = PCT_W'(value);
      directed_rows.push_back(row);
   endtask

   // Compare each transfer on the result side with the oldest expectation
   always @(negedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            flag_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.granted !== want.granted)
               flag_mismatch("granted", int'(rsp_data.granted), int'(want.granted));
            if (rsp_data.granted_index !== want.granted_index)
               flag_mismatch("granted_index", int'(rsp_data.granted_index),
                             int'(want.granted_index));
            if (rsp_data.free_count !== want.free_count)
               flag_mismatch("free_count", int'(rsp_data.free_count),
                             int'(want.free_count));
            if (rsp_data.notify !== want.notify)
               flag_mismatch("notify", int'(rsp_data.notify), int'(want.notify));
            if (rsp_data.overflow_error !== want.overflow_error)
               flag_mismatch("overflow_error", int'(rsp_data.overflow_error),
                             int'(want.overflow_error));
         end
      end
   end

   initial begin
      req_type      r;
      stim_row_type row;
      bit        draining;
      int        linger;
      int        phase;
      int        random_sent;
      int        waited;

      reset_tracker();

      // Directed table: full-stack free, both reserve types, double free,
      // notify at 100, above 100 and 0 percent
      add_checked(FUNC_FREE, TYPE_REQUEST, 6'h2A, mk_rsp(0, 0, 64, 0, 1));
      add_checked(FUNC_RESERVE, TYPE_REQUEST, 0, mk_rsp(1, 63, 63, 0, 0));
      add_checked(FUNC_RESERVE, TYPE_INDICATION, 63, mk_rsp(1, 62, 62, 0, 0));
      add_checked(FUNC_FREE, TYPE_INDICATION, 63, mk_rsp(0, 0, 63, 0, 0));
      add_checked(FUNC_RESERVE, TYPE_INDICATION, 0, mk_rsp(1, 63, 62, 0, 0));
      add_reg(CSR_NOTIFY_ENABLE, 1);
      add_checked(FUNC_FREE, TYPE_REQUEST, 0, mk_rsp(0, 0, 63, 1, 0));
      add_checked(FUNC_FREE, TYPE_REQUEST, 0, mk_rsp(0, 0, 64, 1, 0));
      add_checked(FUNC_FREE, TYPE_REQUEST, 63, mk_rsp(0, 0, 64, 1, 1));
      add_reg(CSR_THRESHOLD_PERCENT, 100);
      add_checked(FUNC_RESERVE, TYPE_REQUEST, 0, mk_rsp(1, 0, 63, 0, 0));
      add_checked(FUNC_FREE, TYPE_REQUEST, 21, mk_rsp(0, 0, 64, 1, 0));
      add_checked(FUNC_RESERVE, TYPE_INDICATION, 0, mk_rsp(1, 21, 63, 0, 0));
      add_access(FUNC_FREE, TYPE_INDICATION, 42);
      add_reg(CSR_THRESHOLD_PERCENT, 127);
      add_checked(FUNC_FREE, TYPE_REQUEST, 5, mk_rsp(0, 0, 64, 0, 1));
      add_access(FUNC_RESERVE, TYPE_INDICATION, 63);
      add_access(FUNC_RESERVE, TYPE_REQUEST, 21);
      add_reg(CSR_THRESHOLD_PERCENT, 0);
      add_access(FUNC_FREE, TYPE_INDICATION, 63);
      add_access(FUNC_RESERVE, TYPE_REQUEST, 0);
      add_access(FUNC_FREE, TYPE_REQUEST, 0);
      add_reg(CSR_NOTIFY_ENABLE, 0);
      add_access(FUNC_FREE, TYPE_REQUEST, 33);

      @(negedge reset);
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if ($urandom_range(0, 5) == 0)
            burst_mode = !burst_mode;
         if (row.kind == ROW_REG)
            write_reg(row.reg_index, row.reg_value);
         else
            send_access(row.req, row.typed, row.want);
      end

      // Random sweeps: each phase drains the pool to empty or fills it to full
      // under a new register setting, then lingers at the end point
      phase       = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case (phase % 5)
            0: begin
               write_reg(CSR_THRESHOLD_PERCENT, 100);
               write_reg(CSR_NOTIFY_ENABLE, 1);
            end
            1: begin
               write_reg(CSR_THRESHOLD_PERCENT, 0);
               write_reg(CSR_NOTIFY_ENABLE, 1);
            end
            2: begin
               write_reg(CSR_THRESHOLD_PERCENT, 127);
               write_reg(CSR_NOTIFY_ENABLE, 1);
            end
            3: begin
               write_reg(CSR_THRESHOLD_PERCENT, PCT_W'($urandom_range(0, 127)));
               write_reg(CSR_NOTIFY_ENABLE, 0);
            end
            default: begin
               write_reg(CSR_THRESHOLD_PERCENT, PCT_W'($urandom_range(0, 100)));
               write_reg(CSR_NOTIFY_ENABLE, 1);
            end
         endcase
         draining = (slots_free >= NUM_ITEMS / 2);
         linger   = 0;
         while (linger < 6) begin
            if ($urandom_range(0, 99) < 80)
               r.func = draining ? FUNC_RESERVE : FUNC_FREE;
            else
               r.func = draining ? FUNC_FREE : FUNC_RESERVE;
            r.item_type  = 1'($urandom_range(0, 1));
            r.item_index = INDEX_W'($urandom_range(0, NUM_ITEMS - 1));
            if ($urandom_range(0, 19) == 0)
               burst_mode = !burst_mode;
            if ($urandom_range(0, 59) == 0) begin
               start <= 1'b0;
               wait_drained();
            end
            send_access(r, 1'b0, '0);
            random_sent++;
            if (draining ? (slots_free == 0) : (slots_free == NUM_ITEMS))
               linger++;
         end
         phase++;
      end

      // Drain what is still in flight
      start <= 1'b0;
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      if (pending_rsp.size() != 0)
         flag_mismatch("results never delivered", 0, pending_rsp.size());
      repeat (4) @(posedge clock);

      $display("covered %0d accesses in %0d sweeps: %0d grants, %0d refused reserves",
               accesses, phase, grants, refusals);
      $display("  %0d full-stack frees, %0d notify pulses, %0d register writes",
               overflows, notifies, reg_writes);
      if (errors == 0) begin
         $display("PASS buffer_free_list_manager_unit");
      end else begin
         $display("FAIL buffer_free_list_manager_unit");
      end
      $finish;
   end

endmodule
